/* hw/rtl/cht_pkg.sv */
// Package: shared types and constants of the cuckoo hash table.
`default_nettype none

package cht_pkg;

  localparam int DefTableDepth = 16;
  localparam int DefKeyBits    = 64;
  localparam int DefValueBits  = 64;
  localparam int CfgIdxW       = 8;

  localparam logic [1:0] CMD_GET    = 2'd0;
  localparam logic [1:0] CMD_PUT    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_LEFT_LO  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LEFT_HI  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_LO = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_HI = CfgIdxW'(3);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] lookup_key;
    logic [63:0] put_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_value;
    logic [63:0] ejected_key;
    logic [5:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] key;
    logic [63:0] seed_lo;
    logic [63:0] seed_hi;
  } hash_req_t;

endpackage

`default_nettype wire

/* hw/rtl/cht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/cht_sip.sv */
// Iterative SipHash-2-4 unit, one half round per cycle, with reciprocal modulo reduction.
`default_nettype none

module cht_sip
  import cht_pkg::*;
#(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int KEY_BITS    = DefKeyBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hash_req_t                      req_i,
  output logic                                done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      idx_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int KeyBytes = KEY_BITS / 8;
  localparam bit Full = (KeyBytes >= 8);
  localparam bit Pow2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
  localparam logic [63:0] ByteMask = Full ? {64{1'b1}} : ((64'd1 << (8 * KeyBytes)) - 64'd1);
  localparam logic [63:0] LenWord  = 64'(KeyBytes & 255) << 56;
  localparam logic [31:0] Depth32  = 32'(TABLE_DEPTH);
  localparam logic [31:0] Recip    = 32'(64'h1_0000_0000 / 64'(TABLE_DEPTH));

  typedef enum logic [3:0] {
    HS_IDLE = 4'b0001,
    HS_COMP = 4'b0010,
    HS_FIN  = 4'b0100,
    HS_MOD  = 4'b1000
  } hs_e;

  hs_e state_q, state_d;
  logic [63:0] v0_q, v1_q, v2_q, v3_q, v0_d, v1_d, v2_d, v3_d;
  logic [63:0] blk_q, blk_d, b_q, b_d, h_q, h_d;
  logic        last_q, last_d, done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  bit_q, bit_d;
  logic [IW-1:0] r_q, r_d, idx_q, idx_d;
  logic [31:0] x_q, x_d, qe_q, qe_d, x_in, rem;
  logic [63:0] prod;
  logic [63:0] n0, n1, n2, n3, hsum, bword;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int b);
    rotl = (x << b) | (x >> (64 - b));
  endfunction

  always_comb begin
    if (!cnt_q[0]) begin
      n0 = v0_q + v1_q;
      n1 = rotl(v1_q, 13) ^ n0;
      n0 = rotl(n0, 32);
      n2 = v2_q + v3_q;
      n3 = rotl(v3_q, 16) ^ n2;
    end else begin
      n0 = v0_q + v3_q;
      n3 = rotl(v3_q, 21) ^ n0;
      n2 = v2_q + v1_q;
      n1 = rotl(v1_q, 17) ^ n2;
      n2 = rotl(n2, 32);
    end
  end

  assign hsum  = n0 ^ n1 ^ n2 ^ n3;
  assign bword = Full ? LenWord : (LenWord | (req_i.key & ByteMask));
  // 16-bit digit step: x = r * 2^16 + digit, quotient estimate low by at most one
  assign x_in  = {16'(r_q), h_q[63:48]};
  assign prod  = 64'(x_in) * 64'(Recip);
  assign rem   = x_q - qe_q * Depth32;

  always_comb begin
    state_d = state_q;
    v0_d = v0_q; v1_d = v1_q; v2_d = v2_q; v3_d = v3_q;
    blk_d = blk_q; b_d = b_q; h_d = h_q; last_d = last_q;
    cnt_d = cnt_q; bit_d = bit_q; r_d = r_q; idx_d = idx_q;
    x_d = x_q; qe_d = qe_q;
    done_d = 1'b0;
    case (state_q)
      HS_IDLE: begin
        if (req_i.start) begin
          blk_d  = Full ? req_i.key : bword;
          b_d    = bword;
          last_d = !Full;
          v0_d   = req_i.seed_lo ^ 64'h736f6d6570736575;
          v1_d   = req_i.seed_hi ^ 64'h646f72616e646f6d;
          v2_d   = req_i.seed_lo ^ 64'h6c7967656e657261;
          v3_d   = req_i.seed_hi ^ 64'h7465646279746573 ^ (Full ? req_i.key : bword);
          cnt_d  = 3'd0;
          state_d = HS_COMP;
        end
      end
      HS_COMP: begin
        v0_d = n0; v1_d = n1; v2_d = n2; v3_d = n3;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          v0_d  = n0 ^ blk_q;
          cnt_d = 3'd0;
          if (!last_q) begin
            blk_d  = b_q;
            v3_d   = n3 ^ b_q;
            last_d = 1'b1;
          end else begin
            v2_d    = n2 ^ 64'hff;
            state_d = HS_FIN;
          end
        end
      end
      HS_FIN: begin
        v0_d = n0; v1_d = n1; v2_d = n2; v3_d = n3;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          if (Pow2) begin
            idx_d   = hsum[IW-1:0];
            done_d  = 1'b1;
            state_d = HS_IDLE;
          end else begin
            h_d     = hsum;
            r_d     = '0;
            bit_d   = 3'd0;
            state_d = HS_MOD;
          end
        end
      end
      HS_MOD: begin
        bit_d = bit_q + 3'd1;
        if (!bit_q[0]) begin
          x_d  = x_in;
          qe_d = prod[63:32];
          h_d  = h_q << 16;
        end else begin
          r_d = (rem >= Depth32) ? IW'(rem - Depth32) : IW'(rem);
          if (bit_q == 3'd7) begin
            idx_d   = r_d;
            done_d  = 1'b1;
            state_d = HS_IDLE;
          end
        end
      end
      default: state_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= 3'd0;
      bit_q   <= 3'd0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q <= v0_d; v1_q <= v1_d; v2_q <= v2_d; v3_q <= v3_d;
    blk_q <= blk_d; b_q <= b_d; h_q <= h_d;
    r_q <= r_d; idx_q <= idx_d;
    x_q <= x_d; qe_q <= qe_d;
  end

  assign done_o = done_q;
  assign idx_o  = idx_q;

endmodule

`default_nettype wire

/* hw/rtl/cuckoo_hash_table.sv */
// Top level: two-table cuckoo hash map with SipHash slot selection.
//
// channel | dir | handshake                     | payload
// in      | in  | in_valid_i / in_ready_o       | in_data_i (in_t)
// out     | out | out_valid_o / out_ready_i     | out_data_o (out_t)
// cfg     | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One command at a time. Each hash compresses one block (two for keys of 8
// bytes) and adds a modulo pass when the depth is not a power of two.
// Get, remove and put without eviction: two hashes, then two slot reads.
// Each eviction step adds one hash and a slot check, at most 2*TABLE_DEPTH steps.
// The result register holds a beat until taken; valid marks clear at reset.
`default_nettype none

module cuckoo_hash_table
  import cht_pkg::*;
#(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int KEY_BITS    = DefKeyBits,
  parameter int VALUE_BITS  = DefValueBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int AW = IW + 1;
  localparam int NS = 1 << AW;
  localparam int CW = $clog2(2 * TABLE_DEPTH + 1);
  localparam int SW = $clog2(2 * TABLE_DEPTH);
  localparam int EW = KEY_BITS + VALUE_BITS;
  localparam logic [SW-1:0] LastStep = SW'(2 * TABLE_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_HL   = 8'b00000010,
    S_HR   = 8'b00000100,
    S_RL   = 8'b00001000,
    S_RR   = 8'b00010000,
    S_EH   = 8'b00100000,
    S_EC   = 8'b01000000,
    S_DONE = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [63:0] lseed_lo_q, lseed_hi_q, rseed_lo_q, rseed_hi_q;
  logic [1:0]  cmd_q, cmd_d;
  logic [KEY_BITS-1:0]   key_q, key_d, okey_q, okey_d, ck_q, ck_d;
  logic [VALUE_BITS-1:0] val_q, val_d, oval_q, oval_d, cv_q, cv_d;
  logic [IW-1:0] li_q, li_d, ri_q, ri_d;
  logic [AW-1:0] ev_q, ev_d;
  logic          lhit_q, lhit_d, side_q, side_d;
  logic [SW-1:0] step_q, step_d;
  logic [CW-1:0] count_q, count_d;
  logic [NS-1:0] valid_q, valid_d;
  logic [1:0]    rst_status_q, rst_status_d;
  logic [63:0]   res_val_q, res_val_d, res_key_q, res_key_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  hash_req_t     hreq;
  logic          hsel_right, h_done;
  logic [IW-1:0] h_idx;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr, l_addr, r_addr, e_addr;
  logic [EW-1:0] wr_data, rd_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic rhit, found;
  logic [AW-1:0] hit_addr;

  assign l_addr = {1'b0, li_q};
  assign r_addr = {1'b1, ri_q};
  assign e_addr = {side_q, h_idx};
  assign rd_key = rd_data[EW-1:VALUE_BITS];
  assign rd_val = rd_data[VALUE_BITS-1:0];
  assign rhit   = valid_q[r_addr] && (rd_key == key_q);
  assign found  = lhit_q || rhit;
  assign hit_addr = lhit_q ? l_addr : r_addr;

  cht_sip #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_sip (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (hreq),
    .done_o(h_done),
    .idx_o (h_idx)
  );

  cht_ram #(
    .WIDTH(EW),
    .DEPTH(NS)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; key_d = key_q; val_d = val_q;
    okey_d = okey_q; oval_d = oval_q; ck_d = ck_q; cv_d = cv_q;
    li_d = li_q; ri_d = ri_q; ev_d = ev_q; lhit_d = lhit_q;
    side_d = side_q; step_d = step_q; count_d = count_q; valid_d = valid_q;
    rst_status_d = rst_status_q; res_val_d = res_val_q; res_key_d = res_key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    hreq.start = 1'b0;
    hreq.key   = 64'(ck_q);
    hsel_right = 1'b1;
    wr_en   = 1'b0;
    wr_addr = l_addr;
    wr_data = {key_q, val_q};
    rd_addr = l_addr;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_data_i.cmd;
          key_d = in_data_i.lookup_key[KEY_BITS-1:0];
          val_d = in_data_i.put_value[VALUE_BITS-1:0];
          res_val_d = '0;
          res_key_d = '0;
          if (in_data_i.cmd != CMD_GET && in_data_i.cmd != CMD_PUT &&
              in_data_i.cmd != CMD_REMOVE) begin
            rst_status_d = ST_ABSENT;
            state_d = S_DONE;
          end else begin
            hreq.start = 1'b1;
            hreq.key   = 64'(in_data_i.lookup_key[KEY_BITS-1:0]);
            hsel_right = 1'b0;
            state_d = S_HL;
          end
        end
      end
      S_HL: begin
        if (h_done) begin
          li_d = h_idx;
          hreq.start = 1'b1;
          hreq.key   = 64'(key_q);
          state_d = S_HR;
        end
      end
      S_HR: begin
        if (h_done) begin
          ri_d = h_idx;
          state_d = S_RL;
        end
      end
      S_RL: begin
        okey_d = rd_key;
        oval_d = rd_val;
        lhit_d = valid_q[l_addr] && (rd_key == key_q);
        rd_addr = r_addr;
        state_d = S_RR;
      end
      S_RR: begin
        rst_status_d = found ? ST_OK : ST_ABSENT;
        state_d = S_DONE;
        case (cmd_q)
          CMD_GET: begin
            if (found) begin
              res_val_d = 64'(lhit_q ? oval_q : rd_val);
            end
          end
          CMD_REMOVE: begin
            if (found) begin
              valid_d[hit_addr] = 1'b0;
              count_d = count_q - CW'(1);
            end
          end
          default: begin
            rst_status_d = ST_OK;
            if (found) begin
              wr_en   = 1'b1;
              wr_addr = hit_addr;
            end else if (!valid_q[l_addr] || !valid_q[r_addr]) begin
              wr_en   = 1'b1;
              wr_addr = valid_q[l_addr] ? r_addr : l_addr;
              valid_d[wr_addr] = 1'b1;
              count_d = count_q + CW'(1);
            end else begin
              wr_en   = 1'b1;
              ck_d    = okey_q;
              cv_d    = oval_q;
              side_d  = 1'b1;
              step_d  = '0;
              hreq.start = 1'b1;
              hreq.key   = 64'(okey_q);
              state_d = S_EH;
            end
          end
        endcase
      end
      S_EH: begin
        hsel_right = side_q;
        if (h_done) begin
          ev_d    = e_addr;
          rd_addr = e_addr;
          state_d = S_EC;
        end
      end
      S_EC: begin
        wr_en   = 1'b1;
        wr_addr = ev_q;
        wr_data = {ck_q, cv_q};
        if (!valid_q[ev_q]) begin
          valid_d[ev_q] = 1'b1;
          count_d = count_q + CW'(1);
          rst_status_d = ST_OK;
          state_d = S_DONE;
        end else begin
          ck_d = rd_key;
          cv_d = rd_val;
          if (step_q == LastStep) begin
            rst_status_d = ST_FULL;
            res_val_d = 64'(rd_val);
            res_key_d = 64'(rd_key);
            state_d = S_DONE;
          end else begin
            step_d = step_q + SW'(1);
            side_d = !side_q;
            hsel_right = !side_q;
            hreq.start = 1'b1;
            hreq.key   = 64'(rd_key);
            state_d = S_EH;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status      = rst_status_q;
          out_d.out_value   = res_val_q;
          out_d.ejected_key = res_key_q;
          out_d.occupancy   = 6'(count_q);
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    hreq.seed_lo = hsel_right ? rseed_lo_q : lseed_lo_q;
    hreq.seed_hi = hsel_right ? rseed_hi_q : lseed_hi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      lseed_lo_q  <= '0;
      lseed_hi_q  <= '0;
      rseed_lo_q  <= '0;
      rseed_hi_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LEFT_LO:  lseed_lo_q <= cfg_data_i;
          CFG_LEFT_HI:  lseed_hi_q <= cfg_data_i;
          CFG_RIGHT_LO: rseed_lo_q <= cfg_data_i;
          CFG_RIGHT_HI: rseed_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; key_q <= key_d; val_q <= val_d;
    okey_q <= okey_d; oval_q <= oval_d; ck_q <= ck_d; cv_q <= cv_d;
    li_q <= li_d; ri_q <= ri_d; ev_q <= ev_d; lhit_q <= lhit_d;
    side_q <= side_d; step_q <= step_d;
    rst_status_q <= rst_status_d; res_val_q <= res_val_d; res_key_q <= res_key_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hw/rtl/cht_checker.sv */
// Port checker for the cuckoo hash table, bound to the top level.
`default_nettype none

module cht_checker
  import cht_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("took a second beat while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == ST_OK || out_data_o.status == ST_ABSENT ||
                    out_data_o.status == ST_FULL)
    else $error("bad status code");

  a_no_eject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_FULL |-> out_data_o.ejected_key == '0)
    else $error("ejected key without full status");

endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (.*);

`default_nettype wire

/* verif/tb_cuckoo_hash_table.sv */
// Testbench for cuckoo_hash_table: directed table then random traffic, checked by a predictor.
`timescale 1ns / 1ps

module tb_cuckoo_hash_table;
  import cht_pkg::*;

  localparam int Depth = DefTableDepth;
  localparam int Slots = 2 * Depth;
  localparam int PoolSize = 48;
  localparam int WatchLimit = 60000;
  localparam int TailCycles = 1500;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = {CfgIdxW{1'b1}};
  localparam logic [63:0] ONES = {64{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  cuckoo_hash_table uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] seed_reg[4];
  logic [63:0] tbl_key[Slots];
  logic [63:0] tbl_val[Slots];
  logic tbl_used[Slots];
  int entries;

  out_t pending_results[$];
  int errors = 0;
  int tx_idle = 37;
  int rx_idle = 77;
  int quiet_cycles = 0;

  function automatic logic [63:0] rotl(logic [63:0] x, int b);
    return (x << b) | (x >> (64 - b));
  endfunction

  function automatic logic [255:0] sip_round(logic [255:0] s);
    logic [63:0] v0, v1, v2, v3;
    {v0, v1, v2, v3} = s;
    v0 += v1; v1 = rotl(v1, 13); v1 ^= v0; v0 = rotl(v0, 32);
    v2 += v3; v3 = rotl(v3, 16); v3 ^= v2;
    v0 += v3; v3 = rotl(v3, 21); v3 ^= v0;
    v2 += v1; v1 = rotl(v1, 17); v1 ^= v2; v2 = rotl(v2, 32);
    return {v0, v1, v2, v3};
  endfunction

  function automatic logic [63:0] sip_hash(logic [63:0] m, logic [63:0] k0, logic [63:0] k1);
    logic [63:0] v0, v1, v2, v3, b;
    logic [255:0] s;
    v0 = k0 ^ 64'h736f6d6570736575;
    v1 = k1 ^ 64'h646f72616e646f6d;
    v2 = k0 ^ 64'h6c7967656e657261;
    v3 = k1 ^ 64'h7465646279746573;
    b = 64'd8 << 56;
    v3 ^= m;
    s = sip_round(sip_round({v0, v1, v2, v3}));
    {v0, v1, v2, v3} = s;
    v0 ^= m;
    v3 ^= b;
    s = sip_round(sip_round({v0, v1, v2, v3}));
    {v0, v1, v2, v3} = s;
    v0 ^= b;
    v2 ^= 64'hFF;
    s = sip_round(sip_round(sip_round(sip_round({v0, v1, v2, v3}))));
    {v0, v1, v2, v3} = s;
    return v0 ^ v1 ^ v2 ^ v3;
  endfunction

  function automatic int home_slot(logic [63:0] k, int side);
    logic [63:0] h;
    h = sip_hash(k, seed_reg[2*side], seed_reg[2*side+1]);
    return side * Depth + int'(h % Depth);
  endfunction

  function automatic out_t table_op(in_t c);
    out_t r;
    int li, ri, hit, idx, side;
    bit found;
    logic [63:0] ck, cv, tk, tv;
    r = '0;
    r.status = ST_ABSENT;
    found = 0;
    hit = 0;
    if (c.cmd != CMD_UNUSED) begin
      li = home_slot(c.lookup_key, 0);
      ri = home_slot(c.lookup_key, 1);
      if (tbl_used[li] && tbl_key[li] == c.lookup_key) begin
        hit = li; found = 1;
      end else if (tbl_used[ri] && tbl_key[ri] == c.lookup_key) begin
        hit = ri; found = 1;
      end
      if (c.cmd == CMD_GET) begin
        if (found) begin
          r.status = ST_OK; r.out_value = tbl_val[hit];
        end
      end else if (c.cmd == CMD_REMOVE) begin
        if (found) begin
          tbl_used[hit] = 0; entries--; r.status = ST_OK;
        end
      end else if (found) begin
        tbl_val[hit] = c.put_value; r.status = ST_OK;
      end else if (!tbl_used[li] || !tbl_used[ri]) begin
        idx = tbl_used[li] ? ri : li;
        tbl_key[idx] = c.lookup_key; tbl_val[idx] = c.put_value; tbl_used[idx] = 1;
        entries++;
        r.status = ST_OK;
      end else begin
        ck = tbl_key[li]; cv = tbl_val[li];
        tbl_key[li] = c.lookup_key; tbl_val[li] = c.put_value;
        side = 1;
        r.status = ST_FULL;
        for (int step = 0; step < Slots; step++) begin
          idx = home_slot(ck, side);
          if (!tbl_used[idx]) begin
            tbl_key[idx] = ck; tbl_val[idx] = cv; tbl_used[idx] = 1;
            entries++;
            r.status = ST_OK;
            break;
          end
          tk = tbl_key[idx]; tv = tbl_val[idx];
          tbl_key[idx] = ck; tbl_val[idx] = cv;
          ck = tk; cv = tv;
          side ^= 1;
        end
        if (r.status == ST_FULL) begin
          r.out_value = cv; r.ejected_key = ck;
        end
      end
    end
    r.occupancy = entries[5:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", out_data_o.out_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
          if (out_data_o.out_value !== want.out_value)
            report_mismatch("out_value", out_data_o.out_value, want.out_value);
          if (out_data_o.ejected_key !== want.ejected_key)
            report_mismatch("ejected_key", out_data_o.ejected_key, want.ejected_key);
          if (out_data_o.occupancy !== want.occupancy)
            report_mismatch("occupancy", 64'(out_data_o.occupancy), 64'(want.occupancy));
        end
      end
    end
  end

  task automatic send_cmd(in_t c);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(table_op(c));
  endtask

  task automatic write_seed(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx <= CFG_RIGHT_HI) seed_reg[idx] = data;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic load_seeds(logic [63:0] ll, logic [63:0] lh, logic [63:0] rl,
                            logic [63:0] rh);
    write_seed(CFG_LEFT_LO, ll);
    write_seed(CFG_LEFT_HI, lh);
    write_seed(CFG_RIGHT_LO, rl);
    write_seed(CFG_RIGHT_HI, rh);
    write_seed(CFG_UNUSED, rand64());
  endtask

  typedef struct {
    in_t c;
    bit typed;
    out_t want;
  } vec_t;

  function automatic vec_t row(logic [1:0] cmd, logic [63:0] k, logic [63:0] v, bit typed,
                               logic [1:0] st, logic [63:0] ov, logic [5:0] occ);
    vec_t r;
    r.c = '{cmd: cmd, lookup_key: k, put_value: v};
    r.typed = typed;
    r.want = '{status: st, out_value: ov, ejected_key: '0, occupancy: occ};
    return r;
  endfunction

  task automatic run_random(int n, ref logic [63:0] pool[PoolSize]);
    in_t c;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      c.cmd = pick < 50 ? CMD_PUT : pick < 78 ? CMD_GET : pick < 95 ? CMD_REMOVE : CMD_UNUSED;
      c.lookup_key = ($urandom_range(9) == 0) ? rand64() : pool[$urandom_range(PoolSize-1)];
      c.put_value = rand64();
      send_cmd(c);
    end
  endtask

  logic [63:0] key_pool[PoolSize];
  vec_t vecs[$];
  out_t got;

  initial begin
    for (int i = 0; i < 4; i++) seed_reg[i] = '0;
    for (int i = 0; i < Slots; i++) tbl_used[i] = 0;
    entries = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_seeds('0, '0, '0, '0);

    vecs.push_back(row(CMD_GET, '0, '0, 1, ST_ABSENT, '0, 6'd0));
    vecs.push_back(row(CMD_REMOVE, ONES, '0, 1, ST_ABSENT, '0, 6'd0));
    vecs.push_back(row(CMD_UNUSED, '0, ONES, 1, ST_ABSENT, '0, 6'd0));
    vecs.push_back(row(CMD_PUT, '0, '0, 1, ST_OK, '0, 6'd1));
    vecs.push_back(row(CMD_PUT, ONES, ONES, 1, ST_OK, '0, 6'd2));
    vecs.push_back(row(CMD_GET, ONES, '0, 1, ST_OK, ONES, 6'd2));
    vecs.push_back(row(CMD_GET, '0, ONES, 1, ST_OK, '0, 6'd2));
    vecs.push_back(row(CMD_PUT, '0, 64'h8000_0000_0000_0001, 1, ST_OK, '0, 6'd2));
    vecs.push_back(row(CMD_GET, '0, '0, 1, ST_OK, 64'h8000_0000_0000_0001, 6'd2));
    vecs.push_back(row(CMD_UNUSED, ONES, '0, 1, ST_ABSENT, '0, 6'd2));
    vecs.push_back(row(CMD_REMOVE, '0, '0, 1, ST_OK, '0, 6'd1));
    vecs.push_back(row(CMD_GET, '0, '0, 1, ST_ABSENT, '0, 6'd1));
    vecs.push_back(row(CMD_REMOVE, '0, '0, 1, ST_ABSENT, '0, 6'd1));
    // same seeds on both sides plus few slots: these collide and build chains
    for (int i = 1; i <= 10; i++)
      vecs.push_back(row(CMD_PUT, 64'(i), 64'(i * 3), 0, ST_OK, '0, '0));
    vecs.push_back(row(CMD_GET, 64'd5, '0, 0, ST_OK, '0, '0));

    foreach (vecs[i]) begin
      if (vecs[i].typed) begin
        in_t c;
        c = vecs[i].c;
        while ($urandom_range(99) < tx_idle) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
        end
        in_valid_i <= 1'b1;
        in_data_i <= c;
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        got = table_op(c);
        if (got != vecs[i].want) report_mismatch("table row", 64'(i), '0);
        pending_results.push_back(got);
      end else begin
        send_cmd(vecs[i].c);
      end
    end
    drain();

    for (int i = 0; i < PoolSize; i++) key_pool[i] = rand64();
    key_pool[0] = '0;
    key_pool[1] = ONES;
    run_random(480, key_pool);
    drain();

    load_seeds(ONES, ONES, ONES, ONES);
    tx_idle = 77;
    rx_idle = 37;
    for (int i = 0; i < PoolSize / 2; i++) key_pool[i] = rand64();
    run_random(480, key_pool);
    drain();

    load_seeds(rand64(), rand64(), rand64(), rand64());
    tx_idle = 0;
    rx_idle = 0;
    for (int i = PoolSize / 2; i < PoolSize; i++) key_pool[i] = rand64();
    run_random(480, key_pool);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0) report_mismatch("results left over", '0, '0);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/cht_pkg.sv
hw/rtl/cht_ram.sv
hw/rtl/cht_sip.sv
hw/rtl/cuckoo_hash_table.sv
hw/rtl/cht_checker.sv
verif/tb_cuckoo_hash_table.sv
